>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// shared constants and types of the billboard quad corner block
// ----------------------------------------------------------------------------
package bqc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int A_WIDTH         = 20;
   localparam int SQRT_STEPS      = 22;
   localparam int DIV_STEPS       = 17;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_IDX_WIDTH   = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_HALF_SIZE    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ASPECT_RATIO = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UP_X         = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UP_Y         = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UP_Z         = 3'd4;

   localparam logic [15:0] HALF_SIZE_RST    = 16'd256;
   localparam logic [15:0] ASPECT_RATIO_RST = 16'd4096;
   localparam logic [15:0] UP_X_RST         = 16'd0;
   localparam logic [15:0] UP_Y_RST         = 16'd16384;
   localparam logic [15:0] UP_Z_RST         = 16'd0;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> design/bqc_front.sv
// ----------------------------------------------------------------------------
// bqc_front
// takes items, forms the eye to center difference and scales it to 20 bits
// ----------------------------------------------------------------------------
module bqc_front import bqc_pkg::*; #(
   parameter int W = COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [W-1:0]   eye [3],
   input  logic signed [W-1:0]   center [3],
   input  q_stat_type            q_stat,
   output logic                  q_push,
   output logic [3*W+63:0]       q_data
);
   localparam int MW  = W + 1;
   localparam int LW  = $clog2(MW + 1);

   logic                 v1_ff, v2_ff, v3_ff;
   logic [MW-1:0]        mag1_ff [3];
   logic [MW-1:0]        mag2_ff [3];
   logic [2:0]           neg1_ff, neg2_ff;
   logic signed [W-1:0]  pos1_ff [3];
   logic signed [W-1:0]  pos2_ff [3];
   logic [LW-1:0]        len2_ff;
   logic                 nz2_ff;
   logic [3*W+63:0]      out_ff;

   logic                 f_en;
   logic [MW-1:0]        mag_in [3];
   logic [2:0]           neg_in;
   logic [MW-1:0]        orv;
   logic [LW-1:0]        len_in;
   logic [3*W+63:0]      out_in;
   logic [MW+A_WIDTH-1:0] sh;

   assign f_en      = !v3_ff || !q_stat.full;
   assign req_stall = !f_en;
   assign q_push    = v3_ff && !q_stat.full;
   assign q_data    = out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = eye[i] < center[i];
         if (neg_in[i]) begin
            mag_in[i] = MW'({center[i][W-1], center[i]}) - MW'({eye[i][W-1], eye[i]});
         end else begin
            mag_in[i] = MW'({eye[i][W-1], eye[i]}) - MW'({center[i][W-1], center[i]});
         end
      end
   end

   always_comb begin
      orv    = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      len_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (orv[i]) begin
            len_in = LW'(i + 1);
         end
      end
   end

   always_comb begin
      out_in = '0;
      sh     = '0;
      for (int i = 0; i < 3; i++) begin
         sh = {mag2_ff[i], {A_WIDTH{1'b0}}} >> len2_ff;
         out_in[i*W +: W] = pos2_ff[i];
         out_in[3*W + 3 + A_WIDTH*i +: A_WIDTH] = sh[A_WIDTH-1:0];
      end
      out_in[3*W +: 3] = neg2_ff;
      out_in[3*W+63]   = nz2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (f_en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         mag1_ff <= mag_in;
         neg1_ff <= neg_in;
         pos1_ff <= center;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         pos2_ff <= pos1_ff;
         len2_ff <= len_in;
         nz2_ff  <= |orv;
         out_ff  <= out_in;
      end
   end

endmodule

>>> design/bqc_queue.sv
// ----------------------------------------------------------------------------
// bqc_queue
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
module bqc_queue import bqc_pkg::*; #(
   parameter int DW = 3 * COORD_WIDTH_DEF + 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] wdata,
   input  logic          pop,
   output logic [DW-1:0] rdata,
   output q_stat_type    q_stat
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DW-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   assign rdata        = mem_ff[rd_ff];
   assign q_stat.full  = cnt_ff == CW'(QUEUE_DEPTH);
   assign q_stat.empty = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

>>> design/bqc_back.sv
// ----------------------------------------------------------------------------
// bqc_back
// square root, divide, cross products, corner sums, one item per cycle unless stalled
// ----------------------------------------------------------------------------
module bqc_back import bqc_pkg::*; #(
   parameter int W = COORD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3*W+63:0]      q_data,
   input  q_stat_type           q_stat,
   output logic                 q_pop,
   input  logic [15:0]          half_size,
   input  logic [15:0]          aspect_ratio,
   input  logic signed [15:0]   up [3],
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [W-1:0]  corner [12]
);
   localparam int SDW = 3 * W + 64;
   localparam int SQB = 2 * SQRT_STEPS - 1;
   localparam int ST_SQ = 1;
   localparam int ST_DV = ST_SQ + SQRT_STEPS + 1;
   localparam int ST_D  = ST_DV + DIV_STEPS + 1;
   localparam int NST   = ST_D + 9;
   localparam int SW    = (W > 36 ? W : 36) + 2;
   localparam int NW    = A_WIDTH + 17;
   localparam int RW    = A_WIDTH + 1;

   logic            valid_ff [NST];
   logic [SDW-1:0]  side_ff [NST];
   logic            b_en;

   logic [2*A_WIDTH-1:0] sqa_ff [3];
   logic [SQB-1:0]       sx_ff [SQRT_STEPS+1];
   logic [SQB-1:0]       sr_ff [SQRT_STEPS+1];
   logic [NW-1:0]        num_ff [DIV_STEPS+1][3];
   logic [RW-1:0]        rem_ff [DIV_STEPS+1][3];
   logic [16:0]          quo_ff [DIV_STEPS+1][3];
   logic [RW-1:0]        dr_ff  [DIV_STEPS+1];
   logic signed [17:0]   d_ff [3];
   logic signed [17:0]   d2_ff [3];
   logic signed [17:0]   d3_ff [3];
   logic signed [33:0]   p1_ff [6];
   logic signed [20:0]   s_ff [3];
   logic signed [20:0]   s3_ff [3];
   logic signed [20:0]   s4_ff [3];
   logic signed [38:0]   p2_ff [6];
   logic signed [20:0]   v_ff [3];
   logic signed [37:0]   hsp_ff [3];
   logic signed [37:0]   vhp_ff [3];
   logic signed [29:0]   hs_ff [3];
   logic signed [29:0]   hs2_ff [3];
   logic signed [54:0]   hvp_ff [3];
   logic signed [34:0]   hv_ff [3];
   logic signed [W-1:0]  c_ff [12];

   assign b_en      = !(valid_ff[NST-1] && rsp_stall);
   assign q_pop     = b_en && !q_stat.empty;
   assign rsp_valid = valid_ff[NST-1];
   assign corner    = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (b_en) begin
         valid_ff[0] <= !q_stat.empty;
         for (int i = 1; i < NST; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         side_ff[0] <= q_data;
         for (int i = 1; i < NST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // squares and their sum
   always_ff @(posedge clock) begin
      if (b_en) begin
         for (int i = 0; i < 3; i++) begin
            sqa_ff[i] <= q_data[3*W+3+A_WIDTH*i +: A_WIDTH] *
                         q_data[3*W+3+A_WIDTH*i +: A_WIDTH];
         end
         sx_ff[0] <= SQB'(sqa_ff[0]) + SQB'(sqa_ff[1]) + SQB'(sqa_ff[2]);
         sr_ff[0] <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [SQB-1:0] bitv, trial, x_in, r_in;
      always_comb begin
         bitv  = SQB'(1) << (2 * (SQRT_STEPS - 1 - k));
         trial = sr_ff[k] + bitv;
         if (sx_ff[k] >= trial) begin
            x_in = sx_ff[k] - trial;
            r_in = (sr_ff[k] >> 1) + bitv;
         end else begin
            x_in = sx_ff[k];
            r_in = sr_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (b_en) begin
            sx_ff[k+1] <= x_in;
            sr_ff[k+1] <= r_in;
         end
      end
   end

   // divider setup
   logic [RW-1:0] root;
   logic [NW-1:0] n_in [3];
   assign root = sr_ff[SQRT_STEPS][RW-1:0];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = {side_ff[ST_DV-1][3*W+3+A_WIDTH*i +: A_WIDTH], 16'b0} +
                   NW'(root >> 1);
      end
   end
   always_ff @(posedge clock) begin
      if (b_en) begin
         dr_ff[0] <= root;
         for (int i = 0; i < 3; i++) begin
            num_ff[0][i] <= n_in[i];
            rem_ff[0][i] <= RW'(n_in[i][NW-1:17]);
            quo_ff[0][i] <= '0;
         end
      end
   end

   // restoring divide, one quotient bit per stage
   for (genvar m = 1; m <= DIV_STEPS; m++) begin : g_div
      logic [RW:0]   t [3];
      logic [RW-1:0] rem_in [3];
      logic [16:0]   quo_in [3];
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i]      = {rem_ff[m-1][i], num_ff[m-1][i][DIV_STEPS-m]};
            quo_in[i] = quo_ff[m-1][i];
            if (t[i] >= {1'b0, dr_ff[m-1]}) begin
               rem_in[i] = RW'(t[i] - {1'b0, dr_ff[m-1]});
               quo_in[i][DIV_STEPS-m] = 1'b1;
            end else begin
               rem_in[i] = t[i][RW-1:0];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (b_en) begin
            dr_ff[m] <= dr_ff[m-1];
            for (int i = 0; i < 3; i++) begin
               num_ff[m][i] <= num_ff[m-1][i];
               rem_ff[m][i] <= rem_in[i];
               quo_ff[m][i] <= quo_in[i];
            end
         end
      end
   end

   logic signed [17:0] d_in [3];
   logic signed [34:0] t1 [3];
   logic signed [39:0] t2 [3];
   logic signed [37:0] hsr [3];
   logic signed [54:0] hvr [3];
   logic [SDW-1:0]     sd_d, sd_o;

   assign sd_d = side_ff[ST_D-1];
   assign sd_o = side_ff[NST-2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!sd_d[3*W+63]) begin
            d_in[i] = '0;
         end else if (sd_d[3*W+i]) begin
            d_in[i] = -$signed({1'b0, quo_ff[DIV_STEPS][i]});
         end else begin
            d_in[i] = $signed({1'b0, quo_ff[DIV_STEPS][i]});
         end
         t1[i]  = 35'(p1_ff[2*i]) - 35'(p1_ff[2*i+1]) + 35'sd8192;
         t2[i]  = 40'(p2_ff[2*i]) - 40'(p2_ff[2*i+1]) + 40'sd32768;
         hsr[i] = hsp_ff[i] + 38'sd128;
         hvr[i] = hvp_ff[i] + 55'sd524288;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i]  <= d_in[i];
            d2_ff[i] <= d_ff[i];
            d3_ff[i] <= d2_ff[i];
            p1_ff[2*i]   <= d_ff[(i+1)%3] * up[(i+2)%3];
            p1_ff[2*i+1] <= d_ff[(i+2)%3] * up[(i+1)%3];
            s_ff[i]  <= t1[i][34:14];
            p2_ff[2*i]   <= s_ff[(i+1)%3] * d3_ff[(i+2)%3];
            p2_ff[2*i+1] <= s_ff[(i+2)%3] * d3_ff[(i+1)%3];
            s3_ff[i] <= s_ff[i];
            v_ff[i]  <= t2[i][36:16];
            s4_ff[i] <= s3_ff[i];
            hsp_ff[i] <= s4_ff[i] * $signed({1'b0, half_size});
            vhp_ff[i] <= v_ff[i] * $signed({1'b0, half_size});
            hs_ff[i]  <= hsr[i][37:8];
            hvp_ff[i] <= vhp_ff[i] * $signed({1'b0, aspect_ratio});
            hs2_ff[i] <= hs_ff[i];
            hv_ff[i]  <= hvr[i][54:20];
         end
      end
   end

   // corner sums with saturation
   logic signed [SW-1:0] sum [12];
   logic signed [W-1:0]  c_in [12];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            sum[3*k+i] = SW'($signed(sd_o[i*W +: W]));
            if (k < 2) begin
               sum[3*k+i] = sum[3*k+i] + SW'(hs2_ff[i]);
            end else begin
               sum[3*k+i] = sum[3*k+i] - SW'(hs2_ff[i]);
            end
            if ((k & 1) == 0) begin
               sum[3*k+i] = sum[3*k+i] + SW'(hv_ff[i]);
            end else begin
               sum[3*k+i] = sum[3*k+i] - SW'(hv_ff[i]);
            end
            if (sum[3*k+i][SW-1:W-1] == '0 || sum[3*k+i][SW-1:W-1] == '1) begin
               c_in[3*k+i] = sum[3*k+i][W-1:0];
            end else if (sum[3*k+i][SW-1]) begin
               c_in[3*k+i] = {1'b1, {(W-1){1'b0}}};
            end else begin
               c_in[3*k+i] = {1'b0, {(W-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         c_ff <= c_in;
      end
   end

endmodule

>>> design/billboard_quad_corners.sv
// ----------------------------------------------------------------------------
// billboard_quad_corners
// camera facing quad corners from eye and particle position
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   eye xyz, center xyz
//   rsp       out   rsp_valid/rsp_stall   four corners xyz
//   csr       in    csr_we                csr_index, csr_wdata
//
// one item per cycle while rsp_stall is low and the queue holds items; the
// back part holds the 22 step square root and 17 step divider pipelines
// synchronous reset clears valid chains and queue pointers, loads csr defaults
// a stalled response holds the back part, the front runs on until the
// four entry queue fills, then req_stall rises
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module billboard_quad_corners import bqc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_eye_x,
   input  logic signed [COORD_WIDTH-1:0] req_eye_y,
   input  logic signed [COORD_WIDTH-1:0] req_eye_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_c0_x,
   output logic signed [COORD_WIDTH-1:0] rsp_c0_y,
   output logic signed [COORD_WIDTH-1:0] rsp_c0_z,
   output logic signed [COORD_WIDTH-1:0] rsp_c1_x,
   output logic signed [COORD_WIDTH-1:0] rsp_c1_y,
   output logic signed [COORD_WIDTH-1:0] rsp_c1_z,
   output logic signed [COORD_WIDTH-1:0] rsp_c2_x,
   output logic signed [COORD_WIDTH-1:0] rsp_c2_y,
   output logic signed [COORD_WIDTH-1:0] rsp_c2_z,
   output logic signed [COORD_WIDTH-1:0] rsp_c3_x,
   output logic signed [COORD_WIDTH-1:0] rsp_c3_y,
   output logic signed [COORD_WIDTH-1:0] rsp_c3_z,
   input  logic                          csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [15:0]                   csr_wdata
);
   localparam int DW = 3 * COORD_WIDTH + 64;

   logic [15:0]        half_ff, ratio_ff;
   logic signed [15:0] up_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= HALF_SIZE_RST;
         ratio_ff <= ASPECT_RATIO_RST;
         up_ff[0] <= UP_X_RST;
         up_ff[1] <= UP_Y_RST;
         up_ff[2] <= UP_Z_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HALF_SIZE:    half_ff  <= csr_wdata;
            REG_ASPECT_RATIO: ratio_ff <= csr_wdata;
            REG_UP_X:         up_ff[0] <= csr_wdata;
            REG_UP_Y:         up_ff[1] <= csr_wdata;
            REG_UP_Z:         up_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [COORD_WIDTH-1:0] eye [3];
   logic signed [COORD_WIDTH-1:0] center [3];
   logic signed [COORD_WIDTH-1:0] corner [12];
   logic                          q_push, q_pop;
   logic [DW-1:0]                 q_wdata, q_rdata;
   q_stat_type                    q_stat;

   assign eye[0]    = req_eye_x;
   assign eye[1]    = req_eye_y;
   assign eye[2]    = req_eye_z;
   assign center[0] = req_center_x;
   assign center[1] = req_center_y;
   assign center[2] = req_center_z;

   bqc_front #(.W(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .eye       (eye),
      .center    (center),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   bqc_queue #(.DW(DW)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .q_stat (q_stat)
   );

   bqc_back #(.W(COORD_WIDTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_data       (q_rdata),
      .q_stat       (q_stat),
      .q_pop        (q_pop),
      .half_size    (half_ff),
      .aspect_ratio (ratio_ff),
      .up           (up_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .corner       (corner)
   );

   assign rsp_c0_x = corner[0];
   assign rsp_c0_y = corner[1];
   assign rsp_c0_z = corner[2];
   assign rsp_c1_x = corner[3];
   assign rsp_c1_y = corner[4];
   assign rsp_c1_z = corner[5];
   assign rsp_c2_x = corner[6];
   assign rsp_c2_y = corner[7];
   assign rsp_c2_z = corner[8];
   assign rsp_c3_x = corner[9];
   assign rsp_c3_y = corner[10];
   assign rsp_c3_z = corner[11];

   `ASSERT_IMPLY(a_stall_needs_full, clock, reset, req_stall, q_stat.full, "stall with room")
   `ASSERT_ALWAYS(a_queue_state, clock, reset, !(q_stat.full && q_stat.empty), "full and empty")
   `ASSERT_IMPLY(a_pop_not_empty, clock, reset, q_pop, !q_stat.empty, "pop while empty")

endmodule

>>> tb/tb_billboard_quad_corners.sv
// ----------------------------------------------------------------------------
// tb_billboard_quad_corners
// self-checking bench for the billboard quad corner block: directed table of
// edge cases then random items with random stalls, every corner compared with
// a fixed point predictor of the normalize, cross and scale chain
// ----------------------------------------------------------------------------
module tb_billboard_quad_corners import bqc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int N_RANDOM = 1780;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed {
      coord_type ex, ey, ez, px, py, pz;
   } pose_type;
   typedef struct {
      coord_type c [12];
   } quad_type;
   typedef struct {
      pose_type  pose;
      logic      fixed;
      coord_type ans;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   coord_type req_eye_x = 0, req_eye_y = 0, req_eye_z = 0;
   coord_type req_center_x = 0, req_center_y = 0, req_center_z = 0;
   coord_type rsp_c [12];
   logic csr_we = 0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   longint half_size, aspect;
   longint up [3];
   quad_type corners_due [$];
   int errors = 0, n_sent = 0, n_seen = 0;
   int tx_idle = 0, rx_idle = 0;
   bit hold_rx = 0;

   billboard_quad_corners dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_eye_x, .req_eye_y, .req_eye_z,
      .req_center_x, .req_center_y, .req_center_z,
      .rsp_valid, .rsp_stall,
      .rsp_c0_x(rsp_c[0]), .rsp_c0_y(rsp_c[1]), .rsp_c0_z(rsp_c[2]),
      .rsp_c1_x(rsp_c[3]), .rsp_c1_y(rsp_c[4]), .rsp_c1_z(rsp_c[5]),
      .rsp_c2_x(rsp_c[6]), .rsp_c2_y(rsp_c[7]), .rsp_c2_z(rsp_c[8]),
      .rsp_c3_x(rsp_c[9]), .rsp_c3_y(rsp_c[10]), .rsp_c3_z(rsp_c[11]),
      .csr_we, .csr_index, .csr_wdata
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_billboard_quad_corners: errors");
      $finish;
   end

   function automatic longint round_shift(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint int_sqrt(longint unsigned x);
      longint unsigned res = 0, bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic quad_type billboard_corners(pose_type p);
      quad_type q;
      longint pos [3], e [3], d [3], s [3], v [3], hs [3], hv [3];
      longint unsigned mag [3], mx, sum;
      bit neg [3];
      longint r, o, tot;
      int len;
      e[0] = p.ex; e[1] = p.ey; e[2] = p.ez;
      pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = e[i] < pos[i];
         mag[i] = neg[i] ? pos[i] - e[i] : e[i] - pos[i];
         if (mag[i] > mx) mx = mag[i];
         d[i] = 0;
      end
      if (mx != 0) begin
         len = 0;
         while (len < 64 && (mx >> len) != 0) len++;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            if (len > 20) mag[i] >>= (len - 20);
            else mag[i] <<= (20 - len);
            sum += mag[i] * mag[i];
         end
         r = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            d[i] = longint'(((mag[i] << 16) + (r >> 1)) / r);
            if (neg[i]) d[i] = -d[i];
         end
      end
      s[0] = round_shift(d[1] * up[2] - d[2] * up[1], 14);
      s[1] = round_shift(d[2] * up[0] - d[0] * up[2], 14);
      s[2] = round_shift(d[0] * up[1] - d[1] * up[0], 14);
      v[0] = round_shift(s[1] * d[2] - s[2] * d[1], 16);
      v[1] = round_shift(s[2] * d[0] - s[0] * d[2], 16);
      v[2] = round_shift(s[0] * d[1] - s[1] * d[0], 16);
      for (int i = 0; i < 3; i++) begin
         hs[i] = round_shift(s[i] * half_size, 8);
         hv[i] = round_shift(v[i] * half_size * aspect, 20);
      end
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            o = ((k < 2) ? hs[i] : -hs[i]) + ((k & 1) ? -hv[i] : hv[i]);
            tot = pos[i] + o;
            if (tot > 64'sh7fffffff) tot = 64'sh7fffffff;
            if (tot < -64'sh80000000) tot = -64'sh80000000;
            q.c[k * 3 + i] = coord_type'(tot);
         end
      end
      return q;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%s", msg);
      errors++;
   endtask

   task automatic write_reg(logic [CSR_IDX_WIDTH-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      unique case (idx)
         REG_HALF_SIZE:    half_size = val;
         REG_ASPECT_RATIO: aspect = val;
         REG_UP_X:         up[0] = longint'($signed(val));
         REG_UP_Y:         up[1] = longint'($signed(val));
         REG_UP_Z:         up[2] = longint'($signed(val));
         default: ;
      endcase
   endtask

   task automatic set_all(logic [15:0] hsz, logic [15:0] ar, logic [15:0] ux,
                          logic [15:0] uy, logic [15:0] uz);
      write_reg(REG_HALF_SIZE, hsz);
      write_reg(REG_ASPECT_RATIO, ar);
      write_reg(REG_UP_X, ux);
      write_reg(REG_UP_Y, uy);
      write_reg(REG_UP_Z, uz);
   endtask

   task automatic drain();
      int guard = 0;
      while (corners_due.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   // sender: valid held until accepted, next item driven on the falling edge
   task automatic send_pose(pose_type p);
      @(negedge clock);
      while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      {req_eye_x, req_eye_y, req_eye_z, req_center_x, req_center_y, req_center_z} <= p;
      corners_due.push_back(billboard_corners(p));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
   endtask

   task automatic lower_valid();
      @(negedge clock);
      req_valid <= 0;
   endtask

   function automatic coord_type rand_coord();
      unique case ($urandom_range(5))
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return coord_type'($signed($urandom) >>> $urandom_range(0, 24));
      endcase
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
      if ($urandom_range(9) < 7) begin
         p.ex = p.px + (coord_type'($signed($urandom)) >>> $urandom_range(4, 30));
         p.ey = p.py + (coord_type'($signed($urandom)) >>> $urandom_range(4, 30));
         p.ez = p.pz + (coord_type'($signed($urandom)) >>> $urandom_range(4, 30));
      end else begin
         p.ex = rand_coord(); p.ey = rand_coord(); p.ez = rand_coord();
      end
      if ($urandom_range(49) == 0) {p.ex, p.ey, p.ez} = {p.px, p.py, p.pz};
      return p;
   endfunction

   // receiver stall and checking
   always @(negedge clock) begin
      if (hold_rx) rsp_stall <= 1;
      else rsp_stall <= (rx_idle > 0) && ($urandom_range(99) < rx_idle);
   end

   always @(posedge clock) begin
      quad_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (corners_due.size() == 0) begin
            report_mismatch($sformatf("unexpected corner item %0d", n_seen));
         end else begin
            want = corners_due.pop_front();
            for (int i = 0; i < 12; i++)
               if (rsp_c[i] !== want.c[i])
                  report_mismatch($sformatf("mismatch item %0d field %0d: got %h want %h",
                                            n_seen, i, rsp_c[i], want.c[i]));
         end
         n_seen++;
      end
   end

   row_type dir_rows [] = '{
      '{'{0, 0, 0, 0, 0, 0}, 1, 0},
      '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1, 32'sh7fffffff},
      '{'{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh80000000}, 1, 32'sh80000000},
      '{'{0, 32'sh10000, 0, 0, 0, 0}, 1, 0},
      '{'{0, 0, 32'sh10000, 0, 0, 0}, 0, 0},
      '{'{32'sh10000, 0, 0, 0, 0, 0}, 0, 0},
      '{'{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 0, 0},
      '{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          32'sh80000000, 32'sh7fffffff, 32'sh80000000}, 0, 0},
      '{'{1, 0, 0, 0, 0, 0}, 0, 0},
      '{'{0, 0, -1, 0, 0, 0}, 0, 0},
      '{'{32'sh7fff0000, 0, 32'sh10000, 32'sh7fff0000, 32'sh1000, 0}, 0, 0},
      '{'{-32'sh40000, 32'sh30000, 32'sh50000, 32'sh1234, -32'sh5678, 32'sh9abc}, 0, 0}
   };

   initial begin
      half_size = HALF_SIZE_RST; aspect = ASPECT_RATIO_RST;
      up[0] = 0; up[1] = $signed(UP_Y_RST); up[2] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 0;

      // directed table under reset settings, then extreme settings
      for (int pass = 0; pass < 3; pass++) begin
         if (pass == 1) set_all(16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff);
         if (pass == 2) set_all(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h8000);
         foreach (dir_rows[i]) begin
            send_pose(dir_rows[i].pose);
            if (pass != 1 && dir_rows[i].fixed)
               for (int j = 0; j < 12; j++)
                  if (corners_due[$].c[j] !== dir_rows[i].ans)
                     report_mismatch($sformatf("table row %0d predictor disagrees", i));
         end
         lower_valid();
         drain();
      end
      write_reg(REG_UNUSED, 16'h1234);

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle = (ph == 0) ? 11 : (ph == 1) ? 77 : 0;
         rx_idle = (ph == 0) ? 77 : (ph == 1) ? 11 : 0;
         for (int blk = 0; blk < 3; blk++) begin
            set_all(16'($urandom), 16'($urandom_range(0, 16384)), 16'($urandom),
                    16'($urandom), 16'($urandom));
            for (int n = 0; n < N_RANDOM / 9; n++) begin
               if (ph == 2 && blk == 1 && n == 20) begin
                  hold_rx = 1;
                  fork
                     begin
                        for (int c = 0; c < 200; c++) @(posedge clock);
                        hold_rx = 0;
                     end
                  join_none
               end
               if (n == 100) begin
                  lower_valid();
                  while (corners_due.size() != 0) @(posedge clock);
               end
               send_pose(rand_pose());
            end
            lower_valid();
            drain();
         end
      end
      set_all(HALF_SIZE_RST, ASPECT_RATIO_RST, UP_X_RST, UP_Y_RST, UP_Z_RST);

      $display("sent %0d items, checked %0d corner sets over %0d register settings",
               n_sent, n_seen, 12);
      if (corners_due.size() != 0)
         report_mismatch($sformatf("%0d corner sets never arrived", corners_due.size()));
      if (errors == 0) begin
         $display("tb_billboard_quad_corners: clean");
      end else begin
         $display("tb_billboard_quad_corners: errors");
      end
      $finish;
   end
endmodule
